// ----- design/sfr_pkg.sv -----
// ============================================================================
// sfr_pkg
// shared types, command codes and framing constants of the sysex chunk framer
// ============================================================================
package sfr_pkg;

    // command codes of an input transaction
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_FETCH  = 2'd2;

    // block layout
    localparam logic [7:0] HEAD_LEN   = 8'd22;
    localparam logic [7:0] SIZE_EXTRA = 8'd23;
    localparam logic [7:0] SIZE_POS   = 8'd6;
    localparam logic [7:0] ZERO_END   = 8'd16;
    localparam logic [7:0] TAG_END    = 8'd20;
    localparam logic [7:0] CMD_POS    = 8'd20;
    localparam logic [7:0] SUB_POS    = 8'd21;
    localparam logic [7:0] TRAILER    = 8'hf7;
    localparam logic [7:0] MASK7      = 8'h7f;
    localparam logic [7:0] PREFIX_LEN = 8'd3;

    // ceil(x / 7) for x below 203: ((x + 6) * 147) >> 10
    localparam logic [7:0] RECIP7     = 8'd147;
    localparam int         RECIP7_SH  = 10;

    // framing geometry of the current chunk
    typedef struct packed {
        logic       empty;
        logic       multi;
        logic       tail_chunk;
        logic [7:0] plen;
        logic [7:0] len8;
        logic [7:0] len7;
    } geom_t;

    // fixed lead bytes of a block
    function automatic logic [7:0] lead_byte(input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = 8'h01;
            3'd1:    b = 8'hfe;
            3'd2:    b = 8'h00;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h53;
            3'd5:    b = 8'hfe;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // tag bytes ahead of the command
    function automatic logic [7:0] tag_byte(input logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = 8'hf0;
            2'd1:    b = 8'h01;
            2'd2:    b = 8'h3a;
            2'd3:    b = 8'h15;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- design/sfr_in_if.sv -----
// ============================================================================
// sfr_in_if
// input channel of the framer: command transactions with valid / ready
// ============================================================================
interface sfr_in_if;

    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [7:0] msg_cmd;
    logic [7:0] msg_sub_cmd;

    modport source (
        output valid,
        input  ready,
        output command,
        output data_byte,
        output msg_cmd,
        output msg_sub_cmd
    );

    modport sink (
        input  valid,
        output ready,
        input  command,
        input  data_byte,
        input  msg_cmd,
        input  msg_sub_cmd
    );

endinterface

// ----- design/sfr_out_if.sv -----
// ============================================================================
// sfr_out_if
// output channel of the framer: one framed byte per transaction
// ============================================================================
interface sfr_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_in_block;
    logic       last_in_message;
    logic       empty_res;
    logic       overflow;

    modport source (
        output valid,
        input  ready,
        output out_byte,
        output last_in_block,
        output last_in_message,
        output empty_res,
        output overflow
    );

    modport sink (
        input  valid,
        output ready,
        input  out_byte,
        input  last_in_block,
        input  last_in_message,
        input  empty_res,
        input  overflow
    );

endinterface

// ----- design/sysex_7bit_chunk_framer_top.sv -----
// ============================================================================
// sysex_7bit_chunk_framer_top
// collects a payload and plays it back one byte per fetch, framed as
// 7-bit packed sysex blocks of up to CHUNK_BYTES payload bytes each
// ============================================================================
// start and append transactions are completed in ST_IDLE and ready stays high after them.
// a fetch passes ST_CLASS and ST_EMIT for a header, empty or trailer byte; a packed
// data byte adds one ST_READ / ST_ACC pair and a top-bits byte over n stored bytes
// adds n pairs, since the single read port of the payload memory reads one byte per pair.
// a finished byte waits in an output register while new transactions enter.
// reset clears counters, pointers, held command bytes and the overflow flag;
// payload memory contents are not cleared.
module sysex_7bit_chunk_framer_top #(
    parameter int MAX_PAYLOAD_BYTES = 4096,
    parameter int CHUNK_BYTES       = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    sfr_in_if.sink    in_ch,
    sfr_out_if.source out_ch
);

    import sfr_pkg::*;

    localparam int MAX_CHUNKS = (MAX_PAYLOAD_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
    localparam int TOT_W      = $clog2(MAX_CHUNKS + 1);
    localparam int CNT_W      = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int AW         = $clog2(MAX_PAYLOAD_BYTES);
    localparam int FILL_W     = $clog2(CHUNK_BYTES + 1);
    localparam int BASE_W     = $clog2(MAX_CHUNKS * CHUNK_BYTES + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLASS = 5'b00010,
        ST_READ  = 5'b00100,
        ST_ACC   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [TOT_W-1:0]  bidx_reg, bidx_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [7:0]        pos_reg, pos_next;
    logic [7:0]        held_cmd_reg, held_cmd_next;
    logic [7:0]        held_sub_reg, held_sub_next;
    logic              ovf_reg, ovf_next;
    logic [7:0]        idx_reg, idx_next;
    logic [2:0]        k_reg, k_next;
    logic [2:0]        n_reg, n_next;
    logic              top_mode_reg, top_mode_next;
    logic [7:0]        acc_reg, acc_next;
    logic              pfx_sel_reg, pfx_sel_next;
    logic [7:0]        pfx_byte_reg, pfx_byte_next;
    logic [7:0]        res_byte_reg, res_byte_next;
    logic              res_blk_reg, res_blk_next;
    logic              res_msg_reg, res_msg_next;
    logic              res_emp_reg, res_emp_next;
    logic              out_valid_reg, out_valid_next;

    logic              in_acc;
    logic              room;
    logic              wr_en;
    logic              rd_en;
    logic              emit_fire;
    logic [7:0]        rd_off;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;
    geom_t             geom;

    assign in_acc    = in_ch.valid && in_ch.ready;
    assign room      = count_reg < CNT_W'(MAX_PAYLOAD_BYTES);
    assign wr_en     = in_acc && (in_ch.command == CMD_APPEND) && room;
    assign rd_en     = state_reg == ST_READ;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || out_ch.ready);

    assign in_ch.ready  = state_reg == ST_IDLE;
    assign out_ch.valid = out_valid_reg;

    // payload store
    sfr_ram #(
        .DEPTH (MAX_PAYLOAD_BYTES),
        .AW    (AW)
    ) u_sfr_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_ch.data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // chunk geometry, sampled on each fetch
    sfr_geom #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .TOT_W       (TOT_W),
        .FILL_W      (FILL_W)
    ) u_sfr_geom (
        .clk         (clk),
        .load        (in_acc && (in_ch.command == CMD_FETCH)),
        .block_index (bidx_reg),
        .total       (total_reg),
        .fill        (fill_reg),
        .geom        (geom)
    );

    // read address of chunk byte idx, skipping the prefix
    assign rd_off  = idx_reg - (geom.multi ? PREFIX_LEN : 8'd0);
    assign rd_addr = AW'(base_reg + BASE_W'(rd_off));

    // sequencer and shared byte unit
    always_comb
    begin
        logic [7:0] q;
        logic [4:0] g;
        logic [2:0] r;
        logic [7:0] g7;
        logic [7:0] diff;
        logic [7:0] b;
        logic [7:0] acc_c;

        q     = pos_reg - HEAD_LEN;
        g     = q[7:3];
        r     = q[2:0];
        g7    = {g, 3'b000} - {3'b000, g};
        diff  = geom.len8 - g7;
        b     = pfx_sel_reg ? pfx_byte_reg : rd_data;
        acc_c = top_mode_reg ? (acc_reg | (8'(b[7]) << k_reg)) : (b & MASK7);

        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        fill_next      = fill_reg;
        bidx_next      = bidx_reg;
        base_next      = base_reg;
        pos_next       = pos_reg;
        held_cmd_next  = held_cmd_reg;
        held_sub_next  = held_sub_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        top_mode_next  = top_mode_reg;
        acc_next       = acc_reg;
        pfx_sel_next   = pfx_sel_reg;
        pfx_byte_next  = pfx_byte_reg;
        res_byte_next  = res_byte_reg;
        res_blk_next   = res_blk_reg;
        res_msg_next   = res_msg_reg;
        res_emp_next   = res_emp_reg;
        out_valid_next = out_valid_reg;

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_ch.command)
                        CMD_START:
                        begin
                            held_cmd_next = in_ch.msg_cmd;
                            held_sub_next = in_ch.msg_sub_cmd;
                            count_next    = '0;
                            total_next    = '0;
                            fill_next     = '0;
                            bidx_next     = '0;
                            base_next     = '0;
                            pos_next      = '0;
                            ovf_next      = 1'b0;
                            acc_next      = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (room)
                            begin
                                count_next = count_reg + CNT_W'(1);
                                if ((total_reg == '0) || (fill_reg == FILL_W'(CHUNK_BYTES)))
                                begin
                                    total_next = total_reg + TOT_W'(1);
                                    fill_next  = FILL_W'(1);
                                end
                                else
                                begin
                                    fill_next = fill_reg + FILL_W'(1);
                                end
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        CMD_FETCH:
                        begin
                            state_next = ST_CLASS;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // classify the byte at the block position
            ST_CLASS:
            begin
                res_blk_next = 1'b0;
                res_msg_next = 1'b0;
                res_emp_next = 1'b0;
                state_next   = ST_EMIT;
                if (geom.empty)
                begin
                    res_byte_next = 8'h00;
                    res_emp_next  = 1'b1;
                end
                else if (pos_reg < SIZE_POS)
                begin
                    res_byte_next = lead_byte(pos_reg[2:0]);
                end
                else if (pos_reg == SIZE_POS)
                begin
                    res_byte_next = geom.len7 + SIZE_EXTRA;
                end
                else if (pos_reg < ZERO_END)
                begin
                    res_byte_next = 8'h00;
                end
                else if (pos_reg < TAG_END)
                begin
                    res_byte_next = tag_byte(pos_reg[1:0]);
                end
                else if (pos_reg == CMD_POS)
                begin
                    res_byte_next = held_cmd_reg;
                end
                else if (pos_reg == SUB_POS)
                begin
                    res_byte_next = held_sub_reg;
                end
                else if ({1'b0, pos_reg} < ({1'b0, HEAD_LEN} + {1'b0, geom.len7}))
                begin
                    // packed data: top-bits byte or one masked byte
                    state_next = ST_READ;
                    k_next     = '0;
                    acc_next   = '0;
                    if (r == 3'd0)
                    begin
                        top_mode_next = 1'b1;
                        idx_next      = g7;
                        n_next        = (diff > 8'd7) ? 3'd7 : diff[2:0];
                    end
                    else
                    begin
                        top_mode_next = 1'b0;
                        idx_next      = g7 + 8'(r) - 8'd1;
                        n_next        = 3'd1;
                    end
                end
                else
                begin
                    res_byte_next = TRAILER;
                    res_blk_next  = 1'b1;
                    res_msg_next  = geom.tail_chunk;
                end
            end

            // issue one chunk byte: prefix register or memory read
            ST_READ:
            begin
                pfx_sel_next = geom.multi && (idx_reg < PREFIX_LEN);
                case (idx_reg[1:0])
                    2'd0:    pfx_byte_next = 8'(total_reg);
                    2'd1:    pfx_byte_next = 8'(bidx_reg);
                    2'd2:    pfx_byte_next = geom.plen;
                    default: pfx_byte_next = 8'h00;
                endcase
                state_next = ST_ACC;
            end

            // fold the byte into the accumulator
            ST_ACC:
            begin
                acc_next = acc_c;
                idx_next = idx_reg + 8'd1;
                k_next   = k_reg + 3'd1;
                if ((k_reg + 3'd1) == n_reg)
                begin
                    res_byte_next = acc_c;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end

            // hand the byte to the output register and, unless the result is empty, advance the pointer
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (!res_emp_reg)
                    begin
                        if (res_blk_reg)
                        begin
                            bidx_next = bidx_reg + TOT_W'(1);
                            base_next = base_reg + BASE_W'(CHUNK_BYTES);
                            pos_next  = '0;
                        end
                        else
                        begin
                            pos_next = pos_reg + 8'd1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            fill_reg      <= '0;
            bidx_reg      <= '0;
            base_reg      <= '0;
            pos_reg       <= '0;
            held_cmd_reg  <= '0;
            held_sub_reg  <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            fill_reg      <= fill_next;
            bidx_reg      <= bidx_next;
            base_reg      <= base_next;
            pos_reg       <= pos_next;
            held_cmd_reg  <= held_cmd_next;
            held_sub_reg  <= held_sub_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers of the byte unit
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        n_reg        <= n_next;
        top_mode_reg <= top_mode_next;
        acc_reg      <= acc_next;
        pfx_sel_reg  <= pfx_sel_next;
        pfx_byte_reg <= pfx_byte_next;
        res_byte_reg <= res_byte_next;
        res_blk_reg  <= res_blk_next;
        res_msg_reg  <= res_msg_next;
        res_emp_reg  <= res_emp_next;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_ch.out_byte        <= res_byte_reg;
            out_ch.last_in_block   <= res_blk_reg;
            out_ch.last_in_message <= res_msg_reg;
            out_ch.empty_res       <= res_emp_reg;
            out_ch.overflow        <= ovf_reg;
        end
    end

endmodule

// ----- design/sfr_ram.sv -----
// ============================================================================
// sfr_ram
// payload store: one write port, one read port with registered read data
// ============================================================================
module sfr_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/sfr_geom.sv -----
// ============================================================================
// sfr_geom
// chunk geometry: payload length, prefixed length and packed length
// of the chunk at the read pointer, registered on each fetch
// ============================================================================
module sfr_geom #(
    parameter int CHUNK_BYTES = 128,
    parameter int TOT_W       = 6,
    parameter int FILL_W      = 8
) (
    input  logic              clk,
    input  logic              load,
    input  logic [TOT_W-1:0]  block_index,
    input  logic [TOT_W-1:0]  total,
    input  logic [FILL_W-1:0] fill,
    output sfr_pkg::geom_t    geom
);

    import sfr_pkg::*;

    logic        last_c;
    logic        multi_c;
    logic [7:0]  plen_c;
    logic [7:0]  len8_c;
    logic [15:0] prod_c;
    logic [7:0]  len7_c;

    // length of the chunk and of its packed form
    always_comb
    begin
        last_c  = ({1'b0, block_index} + {{TOT_W{1'b0}}, 1'b1}) == {1'b0, total};
        multi_c = total > TOT_W'(1);
        plen_c  = last_c ? 8'(fill) : 8'(CHUNK_BYTES);
        len8_c  = plen_c + (multi_c ? PREFIX_LEN : 8'd0);
        prod_c  = 16'(len8_c + 8'd6) * 16'(RECIP7);
        len7_c  = len8_c + 8'(prod_c >> RECIP7_SH);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            geom.empty      <= block_index >= total;
            geom.multi      <= multi_c;
            geom.tail_chunk <= last_c;
            geom.plen       <= plen_c;
            geom.len8       <= len8_c;
            geom.len7       <= len7_c;
        end
    end

endmodule

// ----- design/sfr_chk.sv -----
// ============================================================================
// sfr_chk
// port-level checks of the framer, bound to the top level
// ============================================================================
module sfr_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_command,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last_blk,
    input logic       out_last_msg,
    input logic       out_empty
);

    import sfr_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("output transaction dropped or changed while stalled");

    // an empty result carries a zero byte and no end marks
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_empty |-> out_byte == 8'h00 && !out_last_blk && !out_last_msg)
        else $error("empty result with data or end marks");

    // the end of a message is a block trailer
    a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last_msg |-> out_last_blk && out_byte == TRAILER)
        else $error("message end without block trailer");

    // a fetch occupies the block for at least the next cycle
    a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_command == CMD_FETCH |=> !in_ready)
        else $error("ready right after a fetch transaction");

endmodule

bind sysex_7bit_chunk_framer_top sfr_chk u_sfr_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_command   (in_ch.command),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_byte     (out_ch.out_byte),
    .out_last_blk (out_ch.last_in_block),
    .out_last_msg (out_ch.last_in_message),
    .out_empty    (out_ch.empty_res)
);
